### sv/gpg_pkg.sv
// ----------------------------------------------------------------------------
// gpg_pkg
// shared types, constants and the 0 to 45 degree trig tables of the gradient
// pixel generator
// ----------------------------------------------------------------------------
package gpg_pkg;

    localparam int IMAGE_WIDTH  = 1280;
    localparam int IMAGE_HEIGHT = 720;

    localparam int X_W         = 11;
    localparam int Y_W         = 10;
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 24;
    localparam int ANGLE_W     = 9;
    localparam int CFG_INDEX_W = 2;

    localparam int Q16_W = 17;
    localparam logic [Q16_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;

    // normalize: q0 = (p * RECIP) >> RECIP_SHIFT, then one correction step
    localparam int RECIP_SHIFT = 11;
    localparam int RECIP_W     = 28;
    localparam int DEN_W       = 12;
    localparam int NORM_W      = 27;
    localparam logic [DEN_W-1:0] X_DEN = DEN_W'(IMAGE_WIDTH - 1);
    localparam logic [DEN_W-1:0] Y_DEN = DEN_W'(IMAGE_HEIGHT - 1);
    localparam logic [RECIP_W-1:0] X_RECIP =
        RECIP_W'((64'd1 << (16 + RECIP_SHIFT)) / (IMAGE_WIDTH - 1));
    localparam logic [RECIP_W-1:0] Y_RECIP =
        RECIP_W'((64'd1 << (16 + RECIP_SHIFT)) / (IMAGE_HEIGHT - 1));

    localparam int TRIG_W    = 16;
    localparam int RANGE_W   = 16;
    localparam int OFFSET_W  = 32;
    localparam int NUM_W     = 33;
    localparam int ROOT_W    = 17;
    localparam int TRIG_LAST = 45;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [14:0] q15_mag_t;
    typedef q15_mag_t q15_tab_t [0:TRIG_LAST];

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
        logic [RANGE_W-1:0]       range;
        logic [OFFSET_W-1:0]      offset;
    } trig_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLOR_START   = 2'd0,
        CFG_COLOR_END     = 2'd1,
        CFG_RADIAL_MODE   = 2'd2,
        CFG_ANGLE_DEGREES = 2'd3
    } cfg_reg_t;

    function automatic longint sin_series(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(term);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        return sum;
    endfunction

    function automatic longint cos_series(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
        return sum;
    endfunction

    function automatic q15_mag_t to_q15(longint v);
        longint      vv;
        logic [63:0] m;
        vv = (v < 0) ? 64'sd0 : v;
        m  = (64'(vv) + 64'd16384) >> 15;
        if (m > 64'd32767)
        begin
            m = 64'd32767;
        end
        return q15_mag_t'(m);
    endfunction

    function automatic q15_tab_t build_tab(logic want_sin);
        q15_tab_t    tab;
        logic [63:0] x;
        for (int a = 0; a <= TRIG_LAST; a++)
        begin
            x      = (64'(a) * PI_Q30 + 64'd90) / 64'd180;
            tab[a] = want_sin ? to_q15(sin_series(x)) : to_q15(cos_series(x));
        end
        return tab;
    endfunction

    localparam q15_tab_t SIN_TAB = build_tab(1'b1);
    localparam q15_tab_t COS_TAB = build_tab(1'b0);

endpackage

### sv/gpg_trig_rom.sv
// ----------------------------------------------------------------------------
// gpg_trig_rom
// cos/sin lookup for the configured angle plus projection range and offset
// ----------------------------------------------------------------------------
module gpg_trig_rom (
    input  logic                        clk,
    input  logic [gpg_pkg::ANGLE_W-1:0] angle_degrees,
    output gpg_pkg::trig_t              trig
);

    logic [gpg_pkg::ANGLE_W-1:0]       deg;
    logic [1:0]                        quad;
    logic [6:0]                        rem_deg;
    logic [5:0]                        tab_idx;
    logic signed [gpg_pkg::TRIG_W-1:0] c0;
    logic signed [gpg_pkg::TRIG_W-1:0] s0;
    logic signed [gpg_pkg::TRIG_W-1:0] cos_next;
    logic signed [gpg_pkg::TRIG_W-1:0] sin_next;
    logic signed [gpg_pkg::TRIG_W-1:0] cos_reg;
    logic signed [gpg_pkg::TRIG_W-1:0] sin_reg;
    logic [gpg_pkg::TRIG_W-1:0]        cos_abs;
    logic [gpg_pkg::TRIG_W-1:0]        sin_abs;
    logic [gpg_pkg::TRIG_W-1:0]        cos_neg;
    logic [gpg_pkg::TRIG_W-1:0]        sin_neg;
    gpg_pkg::trig_t                    trig_next;
    gpg_pkg::trig_t                    trig_reg;

    always_comb
    begin
        deg = (angle_degrees >= 9'd360) ? angle_degrees - 9'd360 : angle_degrees;
        priority if (deg >= 9'd270)
        begin
            quad    = 2'd3;
            rem_deg = 7'(deg - 9'd270);
        end
        else if (deg >= 9'd180)
        begin
            quad    = 2'd2;
            rem_deg = 7'(deg - 9'd180);
        end
        else if (deg >= 9'd90)
        begin
            quad    = 2'd1;
            rem_deg = 7'(deg - 9'd90);
        end
        else
        begin
            quad    = 2'd0;
            rem_deg = 7'(deg);
        end
        tab_idx = (rem_deg <= 7'd45) ? 6'(rem_deg) : 6'(7'd90 - rem_deg);
        if (rem_deg <= 7'd45)
        begin
            s0 = $signed({1'b0, gpg_pkg::SIN_TAB[tab_idx]});
            c0 = $signed({1'b0, gpg_pkg::COS_TAB[tab_idx]});
        end
        else
        begin
            c0 = $signed({1'b0, gpg_pkg::SIN_TAB[tab_idx]});
            s0 = $signed({1'b0, gpg_pkg::COS_TAB[tab_idx]});
        end
        unique case (quad)
            2'd0:
            begin
                cos_next = c0;
                sin_next = s0;
            end
            2'd1:
            begin
                cos_next = -s0;
                sin_next = c0;
            end
            2'd2:
            begin
                cos_next = -c0;
                sin_next = -s0;
            end
            default:
            begin
                cos_next = s0;
                sin_next = -c0;
            end
        endcase
    end

    always_comb
    begin
        cos_neg = cos_reg[gpg_pkg::TRIG_W-1] ? 16'(-cos_reg) : '0;
        sin_neg = sin_reg[gpg_pkg::TRIG_W-1] ? 16'(-sin_reg) : '0;
        cos_abs = cos_reg[gpg_pkg::TRIG_W-1] ? cos_neg : 16'(cos_reg);
        sin_abs = sin_reg[gpg_pkg::TRIG_W-1] ? sin_neg : 16'(sin_reg);
        trig_next.cos_val = cos_reg;
        trig_next.sin_val = sin_reg;
        trig_next.range   = cos_abs + sin_abs;
        trig_next.offset  = {cos_neg + sin_neg, 16'h0000};
    end

    always_ff @(posedge clk)
    begin
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        trig_reg <= trig_next;
    end

    assign trig = trig_reg;

endmodule

### sv/gpg_norm.sv
// ----------------------------------------------------------------------------
// gpg_norm
// two-stage normalize of the pixel position to Q1.16 by reciprocal multiply
// ----------------------------------------------------------------------------
module gpg_norm (
    input  logic                      clk,
    input  logic                      en,
    input  gpg_pkg::pixel_t           pixel,
    output logic [gpg_pkg::Q16_W-1:0] nx,
    output logic [gpg_pkg::Q16_W-1:0] ny
);

    localparam int PX_W = gpg_pkg::X_W + gpg_pkg::RECIP_W;
    localparam int PY_W = gpg_pkg::Y_W + gpg_pkg::RECIP_W;

    logic [PX_W-1:0]              px_prod;
    logic [PY_W-1:0]              py_prod;
    logic [gpg_pkg::NORM_W-1:0]   qx0_reg;
    logic [gpg_pkg::NORM_W-1:0]   qy0_reg;
    logic [gpg_pkg::X_W-1:0]      x_reg;
    logic [gpg_pkg::Y_W-1:0]      y_reg;
    logic [gpg_pkg::NORM_W-1:0]   rx;
    logic [gpg_pkg::NORM_W-1:0]   ry;
    logic [gpg_pkg::NORM_W-1:0]   qx;
    logic [gpg_pkg::NORM_W-1:0]   qy;
    logic [gpg_pkg::Q16_W-1:0]    nx_next;
    logic [gpg_pkg::Q16_W-1:0]    ny_next;
    logic [gpg_pkg::Q16_W-1:0]    nx_reg;
    logic [gpg_pkg::Q16_W-1:0]    ny_reg;

    assign px_prod = PX_W'(pixel.pixel_x) * PX_W'(gpg_pkg::X_RECIP);
    assign py_prod = PY_W'(pixel.pixel_y) * PY_W'(gpg_pkg::Y_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx0_reg <= gpg_pkg::NORM_W'(px_prod >> gpg_pkg::RECIP_SHIFT);
            qy0_reg <= gpg_pkg::NORM_W'(py_prod >> gpg_pkg::RECIP_SHIFT);
            x_reg   <= pixel.pixel_x;
            y_reg   <= pixel.pixel_y;
        end
    end

    // one correction step, the estimate is never more than one low
    always_comb
    begin
        rx = gpg_pkg::NORM_W'({x_reg, 16'h0000})
           - gpg_pkg::NORM_W'(qx0_reg * gpg_pkg::NORM_W'(gpg_pkg::X_DEN));
        ry = gpg_pkg::NORM_W'({y_reg, 16'h0000})
           - gpg_pkg::NORM_W'(qy0_reg * gpg_pkg::NORM_W'(gpg_pkg::Y_DEN));
        qx = (rx >= gpg_pkg::NORM_W'(gpg_pkg::X_DEN)) ? qx0_reg + 1'b1 : qx0_reg;
        qy = (ry >= gpg_pkg::NORM_W'(gpg_pkg::Y_DEN)) ? qy0_reg + 1'b1 : qy0_reg;
        nx_next = (qx > gpg_pkg::NORM_W'(gpg_pkg::ONE_Q16)) ? gpg_pkg::ONE_Q16
                                                             : gpg_pkg::Q16_W'(qx);
        ny_next = (qy > gpg_pkg::NORM_W'(gpg_pkg::ONE_Q16)) ? gpg_pkg::ONE_Q16
                                                             : gpg_pkg::Q16_W'(qy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    assign nx = nx_reg;
    assign ny = ny_reg;

endmodule

### sv/gpg_div.sv
// ----------------------------------------------------------------------------
// gpg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module gpg_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gpg_pkg::NUM_W-1:0]    num,
    input  logic [gpg_pkg::RANGE_W-1:0]  range,
    output logic [gpg_pkg::ROOT_W-1:0]   quot
);

    localparam int STEPS = gpg_pkg::ROOT_W;
    localparam int REM_W = gpg_pkg::RANGE_W;

    logic [REM_W-1:0]            rem_reg [0:STEPS-1];
    logic [gpg_pkg::NUM_W-1:0]   num_reg [0:STEPS-1];
    logic [STEPS-1:0]            q_reg   [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        logic [REM_W-1:0]          rem_in;
        logic [gpg_pkg::NUM_W-1:0] num_in;
        logic [STEPS-1:0]          q_in;
        logic [REM_W:0]            trial;
        logic                      ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num[gpg_pkg::NUM_W-1 -: REM_W];
            assign num_in = num;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, num_in[STEPS-1-k]};
            ge    = trial >= {1'b0, range};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? REM_W'(trial - {1'b0, range}) : REM_W'(trial);
                num_reg[k] <= num_in;
                q_reg[k]   <= {q_in[STEPS-2:0], ge};
            end
        end
    end

    assign quot = q_reg[STEPS-1];

endmodule

### sv/gpg_sqrt.sv
// ----------------------------------------------------------------------------
// gpg_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module gpg_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [gpg_pkg::NUM_W-1:0]   value,
    output logic [gpg_pkg::ROOT_W-1:0]  root
);

    localparam int STEPS = gpg_pkg::ROOT_W;
    localparam int VAL_W = 2 * STEPS;
    localparam int REM_W = STEPS + 2;
    localparam int TRY_W = REM_W + 2;

    logic [REM_W-1:0] rem_reg  [0:STEPS-1];
    logic [VAL_W-1:0] val_reg  [0:STEPS-1];
    logic [STEPS-1:0] root_reg [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [VAL_W-1:0] val_in;
        logic [STEPS-1:0] root_in;
        logic [TRY_W-1:0] acc;
        logic [TRY_W-1:0] trial;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign val_in  = VAL_W'(value);
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb
        begin
            acc   = {rem_in, val_in[2*(STEPS-1-k)+1 -: 2]};
            trial = TRY_W'({root_in, 2'b01});
            ge    = acc >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? REM_W'(acc - trial) : REM_W'(acc);
                val_reg[k]  <= val_in;
                root_reg[k] <= {root_in[STEPS-2:0], ge};
            end
        end
    end

    assign root = root_reg[STEPS-1];

endmodule

### sv/gradient_pixel_generator.sv
// ----------------------------------------------------------------------------
// gradient_pixel_generator
// linear or radial gradient colour for one pixel coordinate per beat
// ----------------------------------------------------------------------------
// pixel channel: pixel_valid / pixel_stall carry a pixel beat (column, row)
// color channel: color_valid / color_stall carry the red, green, blue beat
// cfg channel: cfg_valid / cfg_ready write cfg_data to register cfg_index
//   (0 color_start, 1 color_end, 2 radial_mode, 3 angle_degrees);
//   cfg_ready is always high, write only while no pixel is in flight
// throughput: one pixel per cycle while no color beat is stalled, set by a
//   fully pipelined datapath (2 normalize stages, 2 product stages,
//   17 divider / square root stages, 3 blend stages)
// after an angle_degrees write the lookup settles via cos_reg, then trig_reg
// reset: pipeline empties, registers take their reset values
//   (black to white, linear, 0 degrees)
// stall: a stalled color beat holds and the whole pipeline freezes, so
//   pixel_stall follows color_stall while a color beat is waiting
// ----------------------------------------------------------------------------
module gradient_pixel_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_stall,
    input  gpg_pkg::pixel_t                 pixel,
    output logic                            color_valid,
    input  logic                            color_stall,
    output gpg_pkg::color_t                 color,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gpg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gpg_pkg::COLOR_W-1:0]     cfg_data
);

    localparam int DIV_FIRST  = 4;
    localparam int T_STAGE    = DIV_FIRST + gpg_pkg::ROOT_W;
    localparam int PIPE_DEPTH = T_STAGE + 3;
    localparam int LIN_W      = gpg_pkg::Q16_W + 1 + gpg_pkg::TRIG_W;
    localparam int SQ_W       = 31;
    localparam int PROD_W     = gpg_pkg::CH_W + 1 + gpg_pkg::Q16_W + 1;

    logic [gpg_pkg::COLOR_W-1:0] color_start_reg;
    logic [gpg_pkg::COLOR_W-1:0] color_end_reg;
    logic                        radial_mode_reg;
    logic [gpg_pkg::ANGLE_W-1:0] angle_degrees_reg;

    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    gpg_pkg::trig_t             trig;
    logic [gpg_pkg::Q16_W-1:0]  nx;
    logic [gpg_pkg::Q16_W-1:0]  ny;

    logic signed [LIN_W-1:0]    lin_x_reg;
    logic signed [LIN_W-1:0]    lin_y_reg;
    logic [SQ_W-1:0]            sq_x_reg;
    logic [SQ_W-1:0]            sq_y_reg;
    logic signed [17:0]         dx;
    logic signed [17:0]         dy;
    logic signed [35:0]         dx_sq;
    logic signed [35:0]         dy_sq;

    logic [LIN_W:0]             lin_sum;
    logic [gpg_pkg::NUM_W-1:0]  num_reg;
    logic [gpg_pkg::NUM_W-1:0]  d2_reg;

    logic [gpg_pkg::ROOT_W-1:0] quot;
    logic [gpg_pkg::ROOT_W-1:0] root;
    logic [gpg_pkg::Q16_W-1:0]  t_next;
    logic [gpg_pkg::Q16_W-1:0]  t_reg;

    logic signed [PROD_W-1:0]   prod_next [0:2];
    logic signed [PROD_W-1:0]   prod_reg  [0:2];
    logic [gpg_pkg::CH_W-1:0]   ch_next   [0:2];
    gpg_pkg::color_t            color_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_start_reg   <= '0;
            color_end_reg     <= 24'hFFFFFF;
            radial_mode_reg   <= 1'b0;
            angle_degrees_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (gpg_pkg::cfg_reg_t'(cfg_index))
                gpg_pkg::CFG_COLOR_START:   color_start_reg   <= cfg_data;
                gpg_pkg::CFG_COLOR_END:     color_end_reg     <= cfg_data;
                gpg_pkg::CFG_RADIAL_MODE:   radial_mode_reg   <= cfg_data[0];
                gpg_pkg::CFG_ANGLE_DEGREES:
                    angle_degrees_reg <= cfg_data[gpg_pkg::ANGLE_W-1:0];
                default:                    radial_mode_reg   <= radial_mode_reg;
            endcase
        end
    end

    // global pipeline advance
    assign pixel_stall = vld_reg[PIPE_DEPTH-1] && color_stall;
    assign adv         = !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], pixel_valid};
        end
    end

    gpg_trig_rom u_trig (
        .clk           (clk),
        .angle_degrees (angle_degrees_reg),
        .trig          (trig)
    );

    gpg_norm u_norm (
        .clk   (clk),
        .en    (adv),
        .pixel (pixel),
        .nx    (nx),
        .ny    (ny)
    );

    // projection and squared distance products
    always_comb
    begin
        dx    = $signed({1'b0, nx}) - $signed({1'b0, gpg_pkg::HALF_Q16});
        dy    = $signed({1'b0, ny}) - $signed({1'b0, gpg_pkg::HALF_Q16});
        dx_sq = dx * dx;
        dy_sq = dy * dy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin_x_reg <= $signed({1'b0, nx}) * trig.cos_val;
            lin_y_reg <= $signed({1'b0, ny}) * trig.sin_val;
            sq_x_reg  <= SQ_W'(dx_sq);
            sq_y_reg  <= SQ_W'(dy_sq);
        end
    end

    assign lin_sum = {lin_x_reg[LIN_W-1], lin_x_reg} + {lin_y_reg[LIN_W-1], lin_y_reg}
                   + (LIN_W + 1)'(trig.offset);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= lin_sum[LIN_W] ? '0 : gpg_pkg::NUM_W'(lin_sum);
            d2_reg  <= {({1'b0, sq_x_reg} + {1'b0, sq_y_reg}), 1'b0};
        end
    end

    gpg_div u_div (
        .clk   (clk),
        .en    (adv),
        .num   (num_reg),
        .range (trig.range),
        .quot  (quot)
    );

    gpg_sqrt u_sqrt (
        .clk   (clk),
        .en    (adv),
        .value (d2_reg),
        .root  (root)
    );

    // gradient position select and clamp
    always_comb
    begin
        if (radial_mode_reg)
        begin
            t_next = (root > gpg_pkg::ONE_Q16) ? gpg_pkg::ONE_Q16 : root;
        end
        else
        begin
            t_next = (quot > gpg_pkg::ONE_Q16) ? gpg_pkg::ONE_Q16 : quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_next;
        end
    end

    // per-channel blend a + (b - a) * t
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k] = ($signed({1'b0, color_end_reg[(2-k)*8 +: 8]})
                          - $signed({1'b0, color_start_reg[(2-k)*8 +: 8]}))
                          * $signed({1'b0, t_reg});
            ch_next[k]   = 8'(({4'b0, color_start_reg[(2-k)*8 +: 8], 16'h0000}
                          + PROD_W'(prod_reg[k])) >> 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            color_reg.red   <= ch_next[0];
            color_reg.green <= ch_next[1];
            color_reg.blue  <= ch_next[2];
        end
    end

    assign color_valid = vld_reg[PIPE_DEPTH-1];
    assign color       = color_reg;

`ifndef SYNTHESIS
    a_stall_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall == (color_valid && color_stall))
        else $error("pixel stall does not follow a stalled color beat");

    a_pipe_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && color_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while the color beat was stalled");

    a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[T_STAGE] |-> (t_reg <= gpg_pkg::ONE_Q16))
        else $error("gradient position above one");

    a_lin_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[T_STAGE-1] && !radial_mode_reg) |-> (quot <= gpg_pkg::ONE_Q16))
        else $error("linear quotient above one");
`endif

endmodule
